// File: sv/ndp_pkg.sv
package ndp_pkg;

    localparam int FIX_DEPTH = 56;
    localparam int FIX_AW    = 6;
    localparam int BODY_SLOT = 30;
    localparam logic [15:0] BYTE_LIMIT = 16'hFFFF;
    localparam logic [15:0] MIN_LEN    = 16'd8;

    // record kinds
    localparam logic [4:0] K_HDR     = 5'd0;
    localparam logic [4:0] K_ECHO_ID = 5'd1;
    localparam logic [4:0] K_ECHO_SQ = 5'd2;
    localparam logic [4:0] K_TARGET  = 5'd3;
    localparam logic [4:0] K_NA_FLG  = 5'd4;
    localparam logic [4:0] K_RA_HOP  = 5'd5;
    localparam logic [4:0] K_RA_LIFE = 5'd6;
    localparam logic [4:0] K_RA_REACH = 5'd7;
    localparam logic [4:0] K_RA_RETX = 5'd8;
    localparam logic [4:0] K_RD_DST  = 5'd9;
    localparam logic [4:0] K_PTB_MTU = 5'd10;
    localparam logic [4:0] K_EMB_NH  = 5'd11;
    localparam logic [4:0] K_EMB_SRC = 5'd12;
    localparam logic [4:0] K_EMB_DST = 5'd13;
    localparam logic [4:0] K_EMB_PRT = 5'd14;
    localparam logic [4:0] K_PAYLEN  = 5'd15;
    localparam logic [4:0] K_OPT_HDR = 5'd16;
    localparam logic [4:0] K_OPT_LLA = 5'd17;
    localparam logic [4:0] K_OPT_PFL = 5'd18;
    localparam logic [4:0] K_OPT_LIF = 5'd19;
    localparam logic [4:0] K_OPT_PFX = 5'd20;
    localparam logic [4:0] K_OPT_MTU = 5'd21;
    localparam logic [4:0] K_END     = 5'd23;

    // status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_SHORT  = 3'd1;
    localparam logic [2:0] ST_TRUNC  = 3'd2;
    localparam logic [2:0] ST_BADLEN = 3'd3;
    localparam logic [2:0] ST_OVER   = 3'd4;

    // message types
    localparam logic [7:0] T_UNREACH = 8'd1;
    localparam logic [7:0] T_PTB     = 8'd2;
    localparam logic [7:0] T_TIMEX   = 8'd3;
    localparam logic [7:0] T_PARAM   = 8'd4;
    localparam logic [7:0] T_ECHO_RQ = 8'd128;
    localparam logic [7:0] T_ECHO_RP = 8'd129;
    localparam logic [7:0] T_RS      = 8'd133;
    localparam logic [7:0] T_RA      = 8'd134;
    localparam logic [7:0] T_NS      = 8'd135;
    localparam logic [7:0] T_NA      = 8'd136;
    localparam logic [7:0] T_RD      = 8'd137;

    // option types
    localparam logic [7:0] O_SRC_LLA = 8'd1;
    localparam logic [7:0] O_TGT_LLA = 8'd2;
    localparam logic [7:0] O_PREFIX  = 8'd3;
    localparam logic [7:0] O_MTU     = 8'd5;

    // value sources
    localparam logic [2:0] SRC_NONE = 3'd0;
    localparam logic [2:0] SRC_FIX  = 3'd1;
    localparam logic [2:0] SRC_BODY = 3'd2;
    localparam logic [2:0] SRC_LEN  = 3'd3;
    localparam logic [2:0] SRC_OPT  = 3'd4;

    // value register operations
    localparam logic [2:0] VOP_HOLD  = 3'd0;
    localparam logic [2:0] VOP_CLR   = 3'd1;
    localparam logic [2:0] VOP_SHIFT = 3'd2;
    localparam logic [2:0] VOP_LEN   = 3'd3;
    localparam logic [2:0] VOP_OPT   = 3'd4;

    // entries of the record program
    localparam logic [4:0] E_OPT = 5'd20;
    localparam logic [4:0] E_END = 5'd21;
    localparam logic [2:0] J_DONE = 3'd7;

    typedef struct packed {
        logic [4:0] kind;
        logic [2:0] src;
        logic [5:0] off;
        logic [3:0] nbytes;
    } rec_ent_t;

    typedef struct packed {
        logic       take;
        logic       clear;
        logic [2:0] vop;
        logic [2:0] src;
        logic [3:0] opt_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic [7:0] msg_type;
        logic       gt8;
        logic       ge16;
        logic       ge24;
        logic       ge40;
        logic       ge48;
        logic       ge56;
        logic       nh_port;
        logic [2:0] status;
        logic [3:0] opt_count;
        logic [7:0] opt_kind;
        logic [7:0] opt_units;
    } dp_stat_t;

    function automatic logic [5:0] list_start(input logic [7:0] t);
        logic [5:0] s;
        case (t)
            T_NS, T_NA: s = 6'd24;
            T_RS:       s = 6'd8;
            T_RA:       s = 6'd16;
            T_RD:       s = 6'd40;
            default:    s = 6'd0;
        endcase
        return s;
    endfunction

    function automatic rec_ent_t msg_entry(input logic [4:0] e);
        rec_ent_t r;
        unique case (e)
            5'd0:    r = '{K_HDR,     SRC_FIX, 6'd0,  4'd4};
            5'd1:    r = '{K_ECHO_ID, SRC_FIX, 6'd4,  4'd2};
            5'd2:    r = '{K_ECHO_SQ, SRC_FIX, 6'd6,  4'd2};
            5'd3:    r = '{K_NA_FLG,  SRC_FIX, 6'd4,  4'd4};
            5'd4:    r = '{K_TARGET,  SRC_FIX, 6'd8,  4'd8};
            5'd5:    r = '{K_TARGET,  SRC_FIX, 6'd16, 4'd8};
            5'd6:    r = '{K_RA_HOP,  SRC_FIX, 6'd4,  4'd2};
            5'd7:    r = '{K_RA_LIFE, SRC_FIX, 6'd6,  4'd2};
            5'd8:    r = '{K_RA_REACH, SRC_FIX, 6'd8, 4'd4};
            5'd9:    r = '{K_RA_RETX, SRC_FIX, 6'd12, 4'd4};
            5'd10:   r = '{K_RD_DST,  SRC_FIX, 6'd24, 4'd8};
            5'd11:   r = '{K_RD_DST,  SRC_FIX, 6'd32, 4'd8};
            5'd12:   r = '{K_PTB_MTU, SRC_FIX, 6'd4,  4'd4};
            5'd13:   r = '{K_EMB_NH,  SRC_FIX, 6'd14, 4'd1};
            5'd14:   r = '{K_EMB_SRC, SRC_FIX, 6'd16, 4'd8};
            5'd15:   r = '{K_EMB_SRC, SRC_FIX, 6'd24, 4'd8};
            5'd16:   r = '{K_EMB_DST, SRC_FIX, 6'd32, 4'd8};
            5'd17:   r = '{K_EMB_DST, SRC_FIX, 6'd40, 4'd8};
            5'd18:   r = '{K_EMB_PRT, SRC_FIX, 6'd48, 4'd4};
            5'd19:   r = '{K_PAYLEN,  SRC_LEN, 6'd0,  4'd0};
            default: r = '{K_END,     SRC_NONE, 6'd0, 4'd0};
        endcase
        return r;
    endfunction

    function automatic rec_ent_t opt_entry(input logic [2:0] j);
        rec_ent_t r;
        unique case (j)
            3'd0:    r = '{K_OPT_HDR, SRC_OPT,  6'd0,  4'd0};
            3'd1:    r = '{K_OPT_LLA, SRC_BODY, 6'd0,  4'd6};
            3'd2:    r = '{K_OPT_PFL, SRC_BODY, 6'd0,  4'd2};
            3'd3:    r = '{K_OPT_LIF, SRC_BODY, 6'd2,  4'd8};
            3'd4:    r = '{K_OPT_PFX, SRC_BODY, 6'd14, 4'd8};
            3'd5:    r = '{K_OPT_PFX, SRC_BODY, 6'd22, 4'd8};
            3'd6:    r = '{K_OPT_MTU, SRC_BODY, 6'd2,  4'd4};
            default: r = '{K_END,     SRC_NONE, 6'd0,  4'd0};
        endcase
        return r;
    endfunction

endpackage

// File: sv/icmpv6_ndp_message_parser.sv
// ICMPv6 / NDP message parser.
// Input channel s_: one message byte per item (s_data_byte), s_last_byte on the
// final byte. Bytes are taken at one per cycle while a message streams in.
// Result channel m_: 64-bit tagged records (m_record_kind, m_option_index,
// m_record_value), released after the final byte and closed by an end record
// with m_last_record set and m_parse_status holding the outcome.
// Records are released after the final byte. The controller walks the record
// program step by step, skipping steps that do not apply, and every stored byte
// comes through the registered read port of the fix or body ram (S_READ, S_WAIT).
// At most 6 + 5*MAX_OPTIONS records per message.
// While records are being emitted s_ready is low; the next message is taken
// once the end record is accepted. A stall on m_ready holds the current record.
// Reset (aresetn, synchronous) clears counters and the controller; the byte
// rams need no clearing, entries are only read after being written.
module icmpv6_ndp_message_parser #(
    parameter int MAX_OPTIONS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_record_kind,
    output logic [3:0]  m_option_index,
    output logic [63:0] m_record_value,
    output logic [2:0]  m_parse_status,
    output logic        m_last_record
);
    import ndp_pkg::*;

    localparam int BA_W = $clog2(BODY_SLOT * MAX_OPTIONS);
    localparam int AW = (BA_W > FIX_AW) ? BA_W : FIX_AW;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic [AW-1:0] rd_addr;

    ndp_ctrl #(.MAX_OPTIONS(MAX_OPTIONS), .AW(AW)) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_last_byte (s_last_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd),
        .rd_addr     (rd_addr),
        .stat        (stat),
        .rec_kind    (m_record_kind),
        .rec_index   (m_option_index),
        .rec_last    (m_last_record)
    );

    ndp_datapath #(.MAX_OPTIONS(MAX_OPTIONS), .AW(AW)) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .rd_addr     (rd_addr),
        .s_data_byte (s_data_byte),
        .stat        (stat),
        .value       (m_record_value)
    );

    assign m_parse_status = m_last_record ? stat.status : ST_OK;

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while a record is pending");
    a_end_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_record |-> m_record_kind == K_END)
        else $error("end record with wrong kind");
    a_opt_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_option_index != 4'd0 |-> m_record_kind >= K_OPT_HDR)
        else $error("option index on a message record");
    a_end_then_rx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_record |=> s_ready && !m_valid)
        else $error("parser not idle after end record");
`endif
endmodule

// File: sv/ndp_ram.sv
module ndp_ram #(
    parameter int W = 8,
    parameter int D = 56
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);
    logic [W-1:0] mem [D];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: sv/ndp_datapath.sv
module ndp_datapath #(
    parameter int MAX_OPTIONS = 8,
    parameter int AW = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  ndp_pkg::dp_cmd_t cmd,
    input  logic [AW-1:0]    rd_addr,
    input  logic [7:0]       s_data_byte,
    output ndp_pkg::dp_stat_t stat,
    output logic [63:0]      value
);
    import ndp_pkg::*;

    localparam int BODY_DEPTH = BODY_SLOT * MAX_OPTIONS;
    localparam int BA_W = $clog2(BODY_DEPTH);
    localparam int OI_W = (MAX_OPTIONS > 1) ? $clog2(MAX_OPTIONS) : 1;

    logic [15:0] cnt_reg, cnt_next;
    logic [10:0] off_reg, off_next;
    logic [10:0] size_reg, size_next;
    logic [3:0]  ocnt_reg, ocnt_next;
    logic [BA_W-1:0] obase_reg, obase_next;
    logic [2:0]  err_reg, err_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  nh_reg, nh_next;
    logic [63:0] val_reg, val_next;
    logic [7:0]  kind_st [MAX_OPTIONS];
    logic [7:0]  units_st [MAX_OPTIONS];

    logic fix_we, body_we, kind_we, units_we, room;
    logic [10:0] k;
    logic [5:0]  start;
    logic [7:0]  fix_rd, body_rd;
    logic [BA_W-1:0] body_waddr;
    logic [2:0]  status;

    assign room = ocnt_reg < 4'(MAX_OPTIONS);
    assign k = off_reg - 11'd2;
    assign body_waddr = obase_reg + k[BA_W-1:0];
    assign start = list_start(type_reg);

    always_comb begin
        cnt_next = cnt_reg;
        off_next = off_reg;
        size_next = size_reg;
        ocnt_next = ocnt_reg;
        obase_next = obase_reg;
        err_next = err_reg;
        type_next = type_reg;
        nh_next = nh_reg;
        fix_we = 1'b0;
        body_we = 1'b0;
        kind_we = 1'b0;
        units_we = 1'b0;
        if (cmd.clear) begin
            cnt_next = '0;
            off_next = '0;
            size_next = '0;
            ocnt_next = '0;
            obase_next = '0;
            err_next = ST_OK;
        end else if (cmd.take) begin
            if (cnt_reg == BYTE_LIMIT) begin
                err_next = ST_OVER;
            end else begin
                fix_we = cnt_reg < 16'(FIX_DEPTH);
                if (cnt_reg == 16'd0) begin
                    type_next = s_data_byte;
                end
                if (cnt_reg == 16'd14) begin
                    nh_next = s_data_byte;
                end
                if (cnt_reg != 16'd0 && err_reg == ST_OK && start != 6'd0
                        && cnt_reg >= {10'd0, start}) begin
                    // option list walk
                    if (off_reg == 11'd0) begin
                        kind_we = room;
                        size_next = '0;
                        off_next = 11'd1;
                    end else if (off_reg == 11'd1) begin
                        if (s_data_byte == 8'd0) begin
                            err_next = ST_BADLEN;
                        end else begin
                            units_we = room;
                            size_next = {s_data_byte, 3'b000};
                            off_next = 11'd2;
                        end
                    end else begin
                        body_we = room && (k < 11'(BODY_SLOT));
                        off_next = off_reg + 11'd1;
                        if (off_reg + 11'd1 >= size_reg) begin
                            off_next = '0;
                            if (room) begin
                                ocnt_next = ocnt_reg + 4'd1;
                                obase_next = obase_reg + BA_W'(BODY_SLOT);
                            end
                        end
                    end
                end
                cnt_next = cnt_reg + 16'd1;
            end
        end
    end

    always_comb begin
        val_next = val_reg;
        case (cmd.vop)
            VOP_CLR:   val_next = '0;
            VOP_SHIFT: val_next = {val_reg[55:0], (cmd.src == SRC_BODY) ? body_rd : fix_rd};
            VOP_LEN:   val_next = {48'd0, cnt_reg - MIN_LEN};
            VOP_OPT:   val_next = {48'd0, stat.opt_kind, stat.opt_units};
            default:   val_next = val_reg;
        endcase
    end

    always_comb begin
        if (err_reg == ST_OVER) begin
            status = ST_OVER;
        end else if (cnt_reg < MIN_LEN) begin
            status = ST_SHORT;
        end else if (err_reg != ST_OK) begin
            status = err_reg;
        end else if (start != 6'd0 && off_reg != 11'd0) begin
            status = (off_reg == 11'd1) ? ST_TRUNC : ST_BADLEN;
        end else begin
            status = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            off_reg <= '0;
            size_reg <= '0;
            ocnt_reg <= '0;
            obase_reg <= '0;
            err_reg <= ST_OK;
        end else begin
            cnt_reg <= cnt_next;
            off_reg <= off_next;
            size_reg <= size_next;
            ocnt_reg <= ocnt_next;
            obase_reg <= obase_next;
            err_reg <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        type_reg <= type_next;
        nh_reg <= nh_next;
        val_reg <= val_next;
        if (kind_we) begin
            kind_st[ocnt_reg[OI_W-1:0]] <= s_data_byte;
        end
        if (units_we) begin
            units_st[ocnt_reg[OI_W-1:0]] <= s_data_byte;
        end
    end

    ndp_ram #(.W(8), .D(FIX_DEPTH)) u_fix_ram (
        .aclk  (aclk),
        .we    (fix_we),
        .waddr (cnt_reg[FIX_AW-1:0]),
        .wdata (s_data_byte),
        .raddr (rd_addr[FIX_AW-1:0]),
        .rdata (fix_rd)
    );

    ndp_ram #(.W(8), .D(BODY_DEPTH)) u_body_ram (
        .aclk  (aclk),
        .we    (body_we),
        .waddr (body_waddr),
        .wdata (s_data_byte),
        .raddr (rd_addr[BA_W-1:0]),
        .rdata (body_rd)
    );

    always_comb begin
        stat.msg_type = type_reg;
        stat.gt8 = cnt_reg > 16'd8;
        stat.ge16 = cnt_reg >= 16'd16;
        stat.ge24 = cnt_reg >= 16'd24;
        stat.ge40 = cnt_reg >= 16'd40;
        stat.ge48 = cnt_reg >= 16'd48;
        stat.ge56 = cnt_reg >= 16'd56;
        stat.nh_port = (nh_reg == 8'd6) || (nh_reg == 8'd17);
        stat.status = status;
        stat.opt_count = ocnt_reg;
        stat.opt_kind = kind_st[cmd.opt_sel[OI_W-1:0]];
        stat.opt_units = units_st[cmd.opt_sel[OI_W-1:0]];
    end

    assign value = val_reg;
endmodule

// File: sv/ndp_ctrl.sv
module ndp_ctrl #(
    parameter int MAX_OPTIONS = 8,
    parameter int AW = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_last_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output ndp_pkg::dp_cmd_t  cmd,
    output logic [AW-1:0]     rd_addr,
    input  ndp_pkg::dp_stat_t stat,
    output logic [4:0]        rec_kind,
    output logic [3:0]        rec_index,
    output logic              rec_last
);
    import ndp_pkg::*;

    localparam int BA_W = $clog2(BODY_SLOT * MAX_OPTIONS);

    localparam logic [2:0] S_RX   = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [4:0] e_reg, e_next;
    logic [2:0] j_reg, j_next;
    logic [3:0] oi_reg, oi_next;
    logic [BA_W-1:0] base_reg, base_next;
    logic [4:0] kind_reg, kind_next;
    logic [3:0] idx_reg, idx_next;
    logic       last_reg, last_next;
    logic [2:0] src_reg, src_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [3:0] left_reg, left_next;

    rec_ent_t me, oe;
    logic msg_en, sub_en, is_echo, is_err, is_other;
    logic [7:0] t;

    assign t = stat.msg_type;
    assign me = msg_entry(e_reg);
    assign oe = opt_entry(j_reg);
    assign is_echo = (t == T_ECHO_RQ) || (t == T_ECHO_RP);
    assign is_err = (t == T_UNREACH) || (t == T_PTB) || (t == T_TIMEX) || (t == T_PARAM);
    assign is_other = !is_echo && !is_err && list_start(t) == 6'd0;

    always_comb begin
        unique case (e_reg)
            5'd0:           msg_en = 1'b1;
            5'd1, 5'd2:     msg_en = is_echo;
            5'd3:           msg_en = (t == T_NA) && stat.ge24;
            5'd4, 5'd5:     msg_en = (((t == T_NS) || (t == T_NA)) && stat.ge24)
                                     || ((t == T_RD) && stat.ge40);
            5'd6, 5'd7, 5'd8, 5'd9: msg_en = (t == T_RA) && stat.ge16;
            5'd10, 5'd11:   msg_en = (t == T_RD) && stat.ge40;
            5'd12:          msg_en = t == T_PTB;
            5'd13, 5'd14, 5'd15, 5'd16, 5'd17: msg_en = is_err && stat.ge48;
            5'd18:          msg_en = is_err && stat.ge56 && stat.nh_port;
            5'd19:          msg_en = stat.gt8 && (is_echo || is_err || is_other);
            default:        msg_en = 1'b0;
        endcase
    end

    always_comb begin
        unique case (j_reg)
            3'd0:                   sub_en = 1'b1;
            3'd1:                   sub_en = (stat.opt_kind == O_SRC_LLA)
                                             || (stat.opt_kind == O_TGT_LLA);
            3'd2, 3'd3, 3'd4, 3'd5: sub_en = (stat.opt_kind == O_PREFIX)
                                             && (stat.opt_units >= 8'd4);
            3'd6:                   sub_en = stat.opt_kind == O_MTU;
            default:                sub_en = 1'b0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        e_next = e_reg;
        j_next = j_reg;
        oi_next = oi_reg;
        base_next = base_reg;
        kind_next = kind_reg;
        idx_next = idx_reg;
        last_next = last_reg;
        src_next = src_reg;
        addr_next = addr_reg;
        left_next = left_reg;
        cmd.take = 1'b0;
        cmd.clear = 1'b0;
        cmd.vop = VOP_HOLD;
        cmd.src = src_reg;
        cmd.opt_sel = oi_reg;
        unique case (state_reg)
            S_RX: begin
                cmd.take = s_valid;
                if (s_valid && s_last_byte) begin
                    state_next = S_SCAN;
                    e_next = '0;
                    j_next = '0;
                    oi_next = '0;
                    base_next = '0;
                end
            end
            S_SCAN: begin
                if (stat.status != ST_OK || e_reg == E_END) begin
                    kind_next = K_END;
                    idx_next = '0;
                    last_next = 1'b1;
                    cmd.vop = VOP_CLR;
                    state_next = S_OUT;
                end else if (e_reg == E_OPT) begin
                    if (oi_reg >= stat.opt_count) begin
                        e_next = E_END;
                    end else if (j_reg == J_DONE) begin
                        oi_next = oi_reg + 4'd1;
                        j_next = '0;
                        base_next = base_reg + BA_W'(BODY_SLOT);
                    end else if (sub_en) begin
                        kind_next = oe.kind;
                        idx_next = oi_reg;
                        last_next = 1'b0;
                        src_next = oe.src;
                        if (oe.src == SRC_OPT) begin
                            cmd.vop = VOP_OPT;
                            state_next = S_OUT;
                        end else begin
                            cmd.vop = VOP_CLR;
                            addr_next = AW'(base_reg) + AW'(oe.off);
                            left_next = oe.nbytes;
                            state_next = S_READ;
                        end
                    end else begin
                        j_next = j_reg + 3'd1;
                    end
                end else if (msg_en) begin
                    kind_next = me.kind;
                    idx_next = '0;
                    last_next = 1'b0;
                    src_next = me.src;
                    if (me.src == SRC_LEN) begin
                        cmd.vop = VOP_LEN;
                        state_next = S_OUT;
                    end else begin
                        cmd.vop = VOP_CLR;
                        addr_next = AW'(me.off);
                        left_next = me.nbytes;
                        state_next = S_READ;
                    end
                end else begin
                    e_next = e_reg + 5'd1;
                end
            end
            S_READ: begin
                state_next = S_WAIT;
            end
            S_WAIT: begin
                // read data from the ram lands now
                cmd.vop = VOP_SHIFT;
                addr_next = addr_reg + AW'(1);
                left_next = left_reg - 4'd1;
                state_next = (left_reg == 4'd1) ? S_OUT : S_READ;
            end
            S_OUT: begin
                if (m_ready) begin
                    if (last_reg) begin
                        cmd.clear = 1'b1;
                        state_next = S_RX;
                    end else begin
                        if (e_reg == E_OPT) begin
                            j_next = j_reg + 3'd1;
                        end else begin
                            e_next = e_reg + 5'd1;
                        end
                        state_next = S_SCAN;
                    end
                end
            end
            default: begin
                state_next = S_RX;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_RX;
            e_reg <= '0;
            j_reg <= '0;
            oi_reg <= '0;
            base_reg <= '0;
            last_reg <= 1'b0;
            left_reg <= '0;
        end else begin
            state_reg <= state_next;
            e_reg <= e_next;
            j_reg <= j_next;
            oi_reg <= oi_next;
            base_reg <= base_next;
            last_reg <= last_next;
            left_reg <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        idx_reg <= idx_next;
        src_reg <= src_next;
        addr_reg <= addr_next;
    end

    assign s_ready = state_reg == S_RX;
    assign m_valid = state_reg == S_OUT;
    assign rd_addr = addr_reg;
    assign rec_kind = kind_reg;
    assign rec_index = idx_reg;
    assign rec_last = last_reg;

`ifndef ASSERT_OFF
    a_read_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_WAIT |-> left_reg != 4'd0)
        else $error("byte read with no bytes left");
    a_opt_index_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && kind_reg >= K_OPT_HDR && !last_reg |-> idx_reg < 4'(MAX_OPTIONS))
        else $error("option record beyond the store");
    a_out_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(kind_reg) && $stable(idx_reg)
            && $stable(last_reg))
        else $error("record changed while stalled");
`endif
endmodule
